/* src/bsa_pkg.sv */
package bsa_pkg;

    localparam int ADDR_W     = 32;
    localparam int SIZE_W     = 16;
    localparam int STATUS_W   = 2;
    localparam int OUT_IDX_W  = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int WORD_BITS  = 32;
    localparam int BIT_W      = 5;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD_ADDR = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_BYTES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE  = 2'd1;

    localparam logic [SIZE_W-1:0] SLOT_BYTES_RESET = 16'd16;
    localparam logic [ADDR_W-1:0] POOL_BASE_RESET  = 32'd0;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISP,
        ST_ACHK,
        ST_SCAN,
        ST_SCHK,
        ST_AFAIL,
        ST_MUL,
        ST_ADD,
        ST_FCHK,
        ST_FDIV,
        ST_FCLR,
        ST_FBAD,
        ST_EMIT
    } step_t;

    typedef enum logic [3:0] {
        OP_LOAD,
        OP_SPAN,
        OP_WPCLR,
        OP_SCAN,
        OP_NONE,
        OP_RES_FULL,
        OP_MUL,
        OP_RES_ALLOC,
        OP_DIVINIT,
        OP_DIVSTEP,
        OP_RES_FREE,
        OP_RES_BAD,
        OP_EMIT
    } op_t;

    typedef enum logic [3:0] {
        CD_ALWAYS,
        CD_ACCEPT,
        CD_MODE_FREE,
        CD_FULL,
        CD_HIT,
        CD_SCAN_DONE,
        CD_OUT_RANGE,
        CD_DIV_MORE,
        CD_OUT_FREE
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t go_true;
        step_t go_false;
    } ctrl_word_t;

    typedef struct packed {
        logic accept;
        logic mode_free;
        logic full;
        logic hit;
        logic scan_done;
        logic out_range;
        logic div_more;
        logic out_free;
    } flags_t;

    function automatic ctrl_word_t ucode(input step_t s);
        ctrl_word_t w;
        w = '{OP_LOAD, CD_ACCEPT, ST_DISP, ST_IDLE};
        unique case (s)
            ST_IDLE:  w = '{OP_LOAD,      CD_ACCEPT,    ST_DISP,  ST_IDLE};
            ST_DISP:  w = '{OP_SPAN,      CD_MODE_FREE, ST_FCHK,  ST_ACHK};
            ST_ACHK:  w = '{OP_WPCLR,     CD_FULL,      ST_AFAIL, ST_SCAN};
            ST_SCAN:  w = '{OP_SCAN,      CD_HIT,       ST_MUL,   ST_SCHK};
            ST_SCHK:  w = '{OP_NONE,      CD_SCAN_DONE, ST_AFAIL, ST_SCAN};
            ST_AFAIL: w = '{OP_RES_FULL,  CD_ALWAYS,    ST_EMIT,  ST_EMIT};
            ST_MUL:   w = '{OP_MUL,       CD_ALWAYS,    ST_ADD,   ST_ADD};
            ST_ADD:   w = '{OP_RES_ALLOC, CD_ALWAYS,    ST_EMIT,  ST_EMIT};
            ST_FCHK:  w = '{OP_DIVINIT,   CD_OUT_RANGE, ST_FBAD,  ST_FDIV};
            ST_FDIV:  w = '{OP_DIVSTEP,   CD_DIV_MORE,  ST_FDIV,  ST_FCLR};
            ST_FCLR:  w = '{OP_RES_FREE,  CD_ALWAYS,    ST_EMIT,  ST_EMIT};
            ST_FBAD:  w = '{OP_RES_BAD,   CD_ALWAYS,    ST_EMIT,  ST_EMIT};
            ST_EMIT:  w = '{OP_EMIT,      CD_OUT_FREE,  ST_IDLE,  ST_EMIT};
            default:  w = '{OP_LOAD,      CD_ACCEPT,    ST_DISP,  ST_IDLE};
        endcase
        return w;
    endfunction

    function automatic logic [BIT_W-1:0] first_zero(input logic [WORD_BITS-1:0] w);
        logic [BIT_W-1:0] pos;
        pos = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (!w[i])
            begin
                pos = BIT_W'(i);
            end
        end
        return pos;
    endfunction

endpackage

/* src/bsa_sequencer.sv */
module bsa_sequencer (
    input  logic                clk,
    input  logic                rst_n,
    input  bsa_pkg::flags_t     flags,
    output bsa_pkg::ctrl_word_t ctrl
);

    bsa_pkg::step_t step_reg;
    bsa_pkg::step_t step_next;
    logic           take;

    assign ctrl = bsa_pkg::ucode(step_reg);

    always_comb
    begin
        unique case (ctrl.cond)
            bsa_pkg::CD_ALWAYS:    take = 1'b1;
            bsa_pkg::CD_ACCEPT:    take = flags.accept;
            bsa_pkg::CD_MODE_FREE: take = flags.mode_free;
            bsa_pkg::CD_FULL:      take = flags.full;
            bsa_pkg::CD_HIT:       take = flags.hit;
            bsa_pkg::CD_SCAN_DONE: take = flags.scan_done;
            bsa_pkg::CD_OUT_RANGE: take = flags.out_range;
            bsa_pkg::CD_DIV_MORE:  take = flags.div_more;
            bsa_pkg::CD_OUT_FREE:  take = flags.out_free;
            default:               take = 1'b1;
        endcase
        step_next = take ? ctrl.go_true : ctrl.go_false;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= bsa_pkg::ST_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

/* src/bsa_datapath.sv */
module bsa_datapath #(
    parameter int SLOT_COUNT = 128
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  bsa_pkg::ctrl_word_t               ctrl,
    output bsa_pkg::flags_t                   flags,
    input  logic                              in_valid,
    input  logic                              mode,
    input  logic [bsa_pkg::ADDR_W-1:0]        item_address,
    input  logic                              out_stall,
    output logic                              out_valid,
    output logic [bsa_pkg::STATUS_W-1:0]      status,
    output logic [bsa_pkg::OUT_IDX_W-1:0]     slot_index,
    output logic [bsa_pkg::ADDR_W-1:0]        slot_address,
    input  logic                              cfg_valid,
    input  logic [bsa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bsa_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int MAP_WORDS = SLOT_COUNT / bsa_pkg::WORD_BITS;
    localparam int IDX_W     = $clog2(SLOT_COUNT);
    localparam int WI_W      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int WC_W      = $clog2(MAP_WORDS + 1);
    localparam int SPAN_W    = bsa_pkg::SIZE_W + IDX_W;
    localparam int PROD_W    = bsa_pkg::SIZE_W + IDX_W;
    localparam int CNT_W     = $clog2(IDX_W);
    localparam int CAT_W     = WI_W + bsa_pkg::BIT_W;
    localparam int OUT_IDX_W_EXT = bsa_pkg::OUT_IDX_W + IDX_W;

    logic [bsa_pkg::WORD_BITS-1:0]  map_reg [MAP_WORDS];
    logic [bsa_pkg::WORD_BITS-1:0]  map_next [MAP_WORDS];
    logic                           pool_full_reg, pool_full_next;
    logic                           out_valid_reg, out_valid_next;
    logic [bsa_pkg::SIZE_W-1:0]     slot_bytes_reg, slot_bytes_next;
    logic [bsa_pkg::ADDR_W-1:0]     pool_base_reg, pool_base_next;
    logic [WC_W-1:0]                wp_reg, wp_next;
    logic [CNT_W-1:0]               cnt_reg, cnt_next;

    logic                           mode_reg, mode_next;
    logic [bsa_pkg::ADDR_W-1:0]     offset_reg, offset_next;
    logic [SPAN_W-1:0]              span_reg, span_next;
    logic [SPAN_W-1:0]              rem_reg, rem_next;
    logic [SPAN_W-1:0]              dvs_reg, dvs_next;
    logic [IDX_W-1:0]               idx_reg, idx_next;
    logic [PROD_W-1:0]              prod_reg, prod_next;
    logic [bsa_pkg::STATUS_W-1:0]   res_status_reg, res_status_next;
    logic [bsa_pkg::ADDR_W-1:0]     res_addr_reg, res_addr_next;
    logic [bsa_pkg::STATUS_W-1:0]   out_status_reg, out_status_next;
    logic [bsa_pkg::OUT_IDX_W-1:0]  out_index_reg, out_index_next;
    logic [bsa_pkg::ADDR_W-1:0]     out_addr_reg, out_addr_next;

    logic [bsa_pkg::WORD_BITS-1:0]  scan_word;
    logic [bsa_pkg::BIT_W-1:0]      scan_bit;
    logic [CAT_W-1:0]               scan_cat;
    logic [IDX_W-1:0]               free_word;
    logic [OUT_IDX_W_EXT-1:0]       idx_ext;
    logic                           accept;
    logic                           out_free;

    assign accept    = in_valid && (ctrl.op == bsa_pkg::OP_LOAD);
    assign out_free  = !out_valid_reg || !out_stall;
    assign scan_word = map_reg[wp_reg[WI_W-1:0]];
    assign scan_bit  = bsa_pkg::first_zero(scan_word);
    assign scan_cat  = {wp_reg[WI_W-1:0], scan_bit};
    assign free_word = idx_reg >> bsa_pkg::BIT_W;
    assign idx_ext   = {{bsa_pkg::OUT_IDX_W{1'b0}}, idx_reg};

    assign flags.accept    = accept;
    assign flags.mode_free = mode_reg;
    assign flags.full      = pool_full_reg;
    assign flags.hit       = (scan_word != '1);
    assign flags.scan_done = (wp_reg == WC_W'(MAP_WORDS));
    assign flags.out_range = (offset_reg >= bsa_pkg::ADDR_W'(span_reg));
    assign flags.div_more  = (cnt_reg != '0);
    assign flags.out_free  = out_free;

    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign slot_index   = out_index_reg;
    assign slot_address = out_addr_reg;

    always_comb
    begin
        map_next        = map_reg;
        pool_full_next  = pool_full_reg;
        out_valid_next  = out_valid_reg && out_stall;
        slot_bytes_next = slot_bytes_reg;
        pool_base_next  = pool_base_reg;
        wp_next         = wp_reg;
        cnt_next        = cnt_reg;
        mode_next       = mode_reg;
        offset_next     = offset_reg;
        span_next       = span_reg;
        rem_next        = rem_reg;
        dvs_next        = dvs_reg;
        idx_next        = idx_reg;
        prod_next       = prod_reg;
        res_status_next = res_status_reg;
        res_addr_next   = res_addr_reg;
        out_status_next = out_status_reg;
        out_index_next  = out_index_reg;
        out_addr_next   = out_addr_reg;

        if (cfg_valid)
        begin
            if (cfg_index == bsa_pkg::CFG_SLOT_BYTES)
            begin
                slot_bytes_next = cfg_data[bsa_pkg::SIZE_W-1:0];
            end
            else if (cfg_index == bsa_pkg::CFG_POOL_BASE)
            begin
                pool_base_next = cfg_data[bsa_pkg::ADDR_W-1:0];
            end
        end

        unique case (ctrl.op)
            bsa_pkg::OP_LOAD:
            begin
                if (accept)
                begin
                    mode_next   = mode;
                    offset_next = item_address - pool_base_reg;
                end
            end
            bsa_pkg::OP_SPAN:
            begin
                span_next = SPAN_W'(slot_bytes_reg * SLOT_COUNT);
            end
            bsa_pkg::OP_WPCLR:
            begin
                wp_next = '0;
            end
            bsa_pkg::OP_SCAN:
            begin
                if (scan_word != '1)
                begin
                    map_next[wp_reg[WI_W-1:0]][scan_bit] = 1'b1;
                    idx_next = scan_cat[IDX_W-1:0];
                end
                else
                begin
                    wp_next = wp_reg + 1'b1;
                end
            end
            bsa_pkg::OP_NONE:
            begin
            end
            bsa_pkg::OP_RES_FULL:
            begin
                pool_full_next  = 1'b1;
                res_status_next = bsa_pkg::STATUS_FULL;
                idx_next        = '0;
                res_addr_next   = '0;
            end
            bsa_pkg::OP_MUL:
            begin
                prod_next = PROD_W'(idx_reg) * PROD_W'(slot_bytes_reg);
            end
            bsa_pkg::OP_RES_ALLOC:
            begin
                res_status_next = bsa_pkg::STATUS_OK;
                res_addr_next   = pool_base_reg + bsa_pkg::ADDR_W'(prod_reg);
            end
            bsa_pkg::OP_DIVINIT:
            begin
                rem_next = offset_reg[SPAN_W-1:0];
                dvs_next = SPAN_W'({slot_bytes_reg, {(IDX_W-1){1'b0}}});
                idx_next = '0;
                cnt_next = CNT_W'(IDX_W - 1);
            end
            bsa_pkg::OP_DIVSTEP:
            begin
                if (rem_reg >= dvs_reg)
                begin
                    rem_next = rem_reg - dvs_reg;
                    idx_next = {idx_reg[IDX_W-2:0], 1'b1};
                end
                else
                begin
                    idx_next = {idx_reg[IDX_W-2:0], 1'b0};
                end
                dvs_next = dvs_reg >> 1;
                if (cnt_reg != '0)
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            bsa_pkg::OP_RES_FREE:
            begin
                map_next[free_word[WI_W-1:0]][idx_reg[bsa_pkg::BIT_W-1:0]] = 1'b0;
                pool_full_next  = 1'b0;
                res_status_next = bsa_pkg::STATUS_OK;
                res_addr_next   = '0;
            end
            bsa_pkg::OP_RES_BAD:
            begin
                res_status_next = bsa_pkg::STATUS_BAD_ADDR;
                idx_next        = '0;
                res_addr_next   = '0;
            end
            bsa_pkg::OP_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_index_next  = idx_ext[bsa_pkg::OUT_IDX_W-1:0];
                    out_addr_next   = res_addr_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_reg        <= '{default: '0};
            pool_full_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
            slot_bytes_reg <= bsa_pkg::SLOT_BYTES_RESET;
            pool_base_reg  <= bsa_pkg::POOL_BASE_RESET;
            wp_reg         <= '0;
            cnt_reg        <= '0;
        end
        else
        begin
            map_reg        <= map_next;
            pool_full_reg  <= pool_full_next;
            out_valid_reg  <= out_valid_next;
            slot_bytes_reg <= slot_bytes_next;
            pool_base_reg  <= pool_base_next;
            wp_reg         <= wp_next;
            cnt_reg        <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg       <= mode_next;
        offset_reg     <= offset_next;
        span_reg       <= span_next;
        rem_reg        <= rem_next;
        dvs_reg        <= dvs_next;
        idx_reg        <= idx_next;
        prod_reg       <= prod_next;
        res_status_reg <= res_status_next;
        res_addr_reg   <= res_addr_next;
        out_status_reg <= out_status_next;
        out_index_reg  <= out_index_next;
        out_addr_reg   <= out_addr_next;
    end

endmodule

/* src/bitmap_slot_allocator_top.sv */
// channel   direction  handshake              payload
// in        to block   in_valid / in_stall    mode, item_address
// out       from block out_valid / out_stall  status, slot_index, slot_address
// cfg       to block   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one transaction at a time, stepped by the microcode sequencer
// allocate: scans the bitmap word by word for a free bit, then multiplies and adds; refused with full flag set
// free: the slot index comes from the one-bit-per-step divider, dividing the offset by the slot size
// free outside the pool: refused as a bad address; allocate that finds no free slot: refused after every bitmap word
// reset clears the bitmap and full flag at once; slot size returns to 16, pool_base to 0
// a result held by out_stall keeps the sequencer in its emit step; cfg_ready is always high
module bitmap_slot_allocator_top #(
    parameter int SLOT_COUNT = 128
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              mode,
    input  logic [bsa_pkg::ADDR_W-1:0]        item_address,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [bsa_pkg::STATUS_W-1:0]      status,
    output logic [bsa_pkg::OUT_IDX_W-1:0]     slot_index,
    output logic [bsa_pkg::ADDR_W-1:0]        slot_address,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bsa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bsa_pkg::CFG_DATA_W-1:0]    cfg_data
);

    bsa_pkg::ctrl_word_t ctrl;
    bsa_pkg::flags_t     flags;

    assign in_stall  = (ctrl.op != bsa_pkg::OP_LOAD);
    assign cfg_ready = 1'b1;

    bsa_sequencer u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctrl  (ctrl)
    );

    bsa_datapath #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .flags        (flags),
        .in_valid     (in_valid),
        .mode         (mode),
        .item_address (item_address),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .status       (status),
        .slot_index   (slot_index),
        .slot_address (slot_address),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

endmodule
